>>> hw/rtl/stx_etx_frame_receiver_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame receiver
// Wrappers around concurrent assertions that disappear in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef STX_ETX_FRAME_RECEIVER_TOP_MACROS_SVH
`define STX_ETX_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SEFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame receiver assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SEFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame receiver assertion failed");
`else
`define SEFR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define SEFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/sefr_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Transaction types, register indexes, event codes and frame constants.
// ----------------------------------------------------------------------------
package sefr_pkg;

    // Frame geometry: start, opcode and length precede the payload.
    localparam int HEADER_BYTES   = 3;
    localparam int OVERHEAD_BYTES = 4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_BYTE   = 3'd0;
    localparam logic [2:0] CFG_END_BYTE     = 3'd1;
    localparam logic [2:0] CFG_OP_LIMIT     = 3'd2;
    localparam logic [2:0] CFG_SMALL_BLOCK  = 3'd3;
    localparam logic [2:0] CFG_MEDIUM_BLOCK = 3'd4;

    // Event codes reported with every result.
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_HEADER = 3'd1;
    localparam logic [2:0] EV_STORED = 3'd2;
    localparam logic [2:0] EV_DONE   = 3'd3;
    localparam logic [2:0] EV_DROP   = 3'd4;

    // Buffer size classes.
    localparam logic [1:0] CLASS_SMALL  = 2'd0;
    localparam logic [1:0] CLASS_MEDIUM = 2'd1;
    localparam logic [1:0] CLASS_LARGE  = 2'd2;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] op_limit;
        logic [8:0] small_block_size;
        logic [8:0] medium_block_size;
    } sefr_cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_available;
    } sefr_in_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] byte_value;
        logic [8:0] byte_index;
        logic [7:0] op_code;
        logic [7:0] payload_length;
        logic [1:0] pool_class;
        logic [8:0] frame_length;
    } sefr_out_t;

endpackage

>>> hw/rtl/sefr_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Holds the frame state and works out the result for one received byte.
// ----------------------------------------------------------------------------
module sefr_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  sefr_pkg::sefr_in_t  din,
    input  sefr_pkg::sefr_cfg_t cfg,
    output sefr_pkg::sefr_out_t res
);
    import sefr_pkg::*;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_OP    = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_END   = 3'd4;

    localparam logic [8:0] HEADER_W   = 9'(HEADER_BYTES);
    localparam logic [8:0] OVERHEAD_W = 9'(OVERHEAD_BYTES);

    logic [2:0] phase_reg, phase_next;
    logic [8:0] write_position_reg, write_position_next;
    logic [7:0] held_opcode_reg, held_opcode_next;
    logic [7:0] held_length_reg, held_length_next;
    logic [1:0] held_class_reg, held_class_next;

    logic [8:0] frame_size;
    logic [1:0] size_class;
    logic [8:0] position_inc;
    logic [8:0] data_end;

    // Size class of the frame announced by the incoming length byte.
    assign frame_size   = {1'b0, din.data_byte} + OVERHEAD_W;
    assign size_class   = (frame_size > cfg.medium_block_size) ? CLASS_LARGE :
                          (frame_size > cfg.small_block_size)  ? CLASS_MEDIUM :
                                                                 CLASS_SMALL;
    assign position_inc = write_position_reg + 9'd1;
    assign data_end     = {1'b0, held_length_reg} + HEADER_W;

    // Next state and the event for the current byte.
    always_comb
    begin
        phase_next          = phase_reg;
        write_position_next = write_position_reg;
        held_opcode_next    = held_opcode_reg;
        held_length_next    = held_length_reg;
        held_class_next     = held_class_reg;
        res.event_res       = EV_NONE;
        res.byte_value      = 8'd0;
        res.byte_index      = 9'd0;
        res.frame_length    = 9'd0;

        case (phase_reg)
            PH_OP:
            begin
                if (din.data_byte < cfg.op_limit)
                begin
                    held_opcode_next = din.data_byte;
                    phase_next       = PH_LEN;
                end
                else
                begin
                    res.event_res = EV_DROP;
                    phase_next    = PH_START;
                end
            end
            PH_LEN:
            begin
                held_length_next = din.data_byte;
                if (din.data_byte == 8'd0)
                begin
                    // An empty frame claims no buffer and goes to the end byte.
                    held_class_next     = CLASS_SMALL;
                    write_position_next = HEADER_W;
                    res.event_res       = EV_HEADER;
                    phase_next          = PH_END;
                end
                else
                begin
                    held_class_next = size_class;
                    if (din.buffer_available)
                    begin
                        write_position_next = HEADER_W;
                        res.event_res       = EV_HEADER;
                        phase_next          = PH_DATA;
                    end
                    else
                    begin
                        res.event_res = EV_DROP;
                        phase_next    = PH_START;
                    end
                end
            end
            PH_DATA:
            begin
                res.event_res       = EV_STORED;
                res.byte_value      = din.data_byte;
                res.byte_index      = write_position_reg;
                write_position_next = position_inc;
                if (position_inc == data_end)
                begin
                    phase_next = PH_END;
                end
            end
            PH_END:
            begin
                if (din.data_byte == cfg.end_byte)
                begin
                    res.event_res = EV_DONE;
                    if (held_length_reg != 8'd0)
                    begin
                        res.byte_value = cfg.end_byte;
                        res.byte_index = write_position_reg;
                    end
                    res.frame_length = {1'b0, held_length_reg} + OVERHEAD_W;
                end
                else
                begin
                    res.event_res = EV_DROP;
                end
                phase_next = PH_START;
            end
            default:
            begin
                // Waiting for the start byte; unused codes land here too.
                phase_next = (din.data_byte == cfg.start_byte) ? PH_OP : PH_START;
            end
        endcase

        res.op_code        = held_opcode_next;
        res.payload_length = held_length_next;
        res.pool_class     = held_class_next;
    end

    // State advances only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_START;
            write_position_reg <= 9'd0;
            held_opcode_reg    <= 8'd0;
            held_length_reg    <= 8'd0;
            held_class_reg     <= CLASS_SMALL;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            write_position_reg <= write_position_next;
            held_opcode_reg    <= held_opcode_next;
            held_length_reg    <= held_length_next;
            held_class_reg     <= held_class_next;
        end
    end

endmodule

>>> hw/rtl/stx_etx_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// STX/ETX frame receiver, top level
// The result of an accepted byte is registered in the output register.
// Throughput: one byte per cycle while out_ready is high; the parser updates in one pass.
// A new byte is taken while a result waits, as long as out_ready is high.
// Reset (rst_n low, asynchronous) restores default registers and waits for start.
// ----------------------------------------------------------------------------
`include "stx_etx_frame_receiver_top_macros.svh"

module stx_etx_frame_receiver_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [2:0]          cfg_index,
    input  logic [8:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  sefr_pkg::sefr_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sefr_pkg::sefr_out_t out_data
);
    import sefr_pkg::*;

    sefr_cfg_t cfg_reg;
    sefr_out_t result;
    sefr_out_t out_data_reg;
    logic      out_valid_reg;
    logic      in_accept;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte        <= 8'd2;
            cfg_reg.end_byte          <= 8'd3;
            cfg_reg.op_limit          <= 8'd7;
            cfg_reg.small_block_size  <= 9'd32;
            cfg_reg.medium_block_size <= 9'd128;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_START_BYTE:   cfg_reg.start_byte        <= cfg_data[7:0];
                CFG_END_BYTE:     cfg_reg.end_byte          <= cfg_data[7:0];
                CFG_OP_LIMIT:     cfg_reg.op_limit          <= cfg_data[7:0];
                CFG_SMALL_BLOCK:  cfg_reg.small_block_size  <= cfg_data;
                CFG_MEDIUM_BLOCK: cfg_reg.medium_block_size <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input is taken whenever the output register is free or being drained.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    sefr_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_accept),
        .din   (in_data),
        .cfg   (cfg_reg),
        .res   (result)
    );

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A waiting result must block new input.
    `SEFR_ASSERT_IMPLIES(a_no_overrun, clk, rst_n, out_valid && !out_ready, !in_ready)
    // Every accepted byte shows a result in the next cycle.
    `SEFR_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)
    // Frame length is reported only on completion.
    `SEFR_ASSERT_IMPLIES(a_len_on_done, clk, rst_n, out_valid && (out_data.event_res != EV_DONE), out_data.frame_length == 9'd0)

endmodule
